FILE: src/text_console_writer_top_macros.svh
// Assertion macros for the text console writer.
// Expects clk and arst_n in the scope of each use; the bodies are empty under SYNTH.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text console writer: check failed");
// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text console writer: check failed");
`else
`define TCW_ASSERT_IMPL(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/tcw_pkg.sv
// Shared constants, types and command format for the text console writer.
// No dependencies; the front, queue, back and top refer to it by scoped names.
package tcw_pkg;

	// Screen geometry
	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;

	// Field widths of the item and result
	localparam int KIND_W = 2;
	localparam int CHAR_W = 8;
	localparam int POS_W  = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CFG_IDX_W = 2;

	// Internal widths
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CNT_W   = $clog2(CELLS + 1);
	localparam int CIDX_W  = $clog2(COLS);
	localparam int RIDX_W  = $clog2(ROWS);
	localparam int CELL_W  = 2 * CHAR_W;

	// Division of a position by COLS through a reciprocal
	localparam int DIV_SHIFT = 16;
	localparam int DIV_RECIP = (1 << DIV_SHIFT) / COLS;
	localparam int PROD_W    = POS_W + DIV_SHIFT;
	localparam int QUO_W     = $clog2(((1 << POS_W) / COLS) + 2);

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [CHAR_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CIDX_W-1:0] cidx_t;
	typedef logic [RIDX_W-1:0] ridx_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [QUO_W-1:0]  quo_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam byte_t NEWLINE_CODE = 8'h0a;
	localparam byte_t BLINK_BIT    = 8'h80;
	localparam byte_t BLANK_CHAR   = 8'h00;

	localparam byte_t PROMPT_CHAR_RST  = 8'd62;
	localparam byte_t PROMPT_COLOR_RST = 8'd10;
	localparam byte_t ERASE_ATTR_RST   = 8'h02;

	localparam cfg_idx_t CFG_PROMPT_CHAR  = 2'd0;
	localparam cfg_idx_t CFG_PROMPT_COLOR = 2'd1;
	localparam cfg_idx_t CFG_ERASE_ATTR   = 2'd2;

	localparam ridx_t LAST_ROW    = ridx_t'(ROWS - 1);
	localparam cidx_t LAST_COL    = cidx_t'(COLS - 1);
	localparam addr_t BOTTOM_BASE = addr_t'((ROWS - 1) * COLS);
	localparam cnt_t  SCROLL_SRC  = cnt_t'(2 * COLS);
	localparam cnt_t  CELL_COUNT  = cnt_t'(CELLS);
	localparam cnt_t  LAST_CELL   = cnt_t'(CELLS - 1);
	localparam cnt_t  BOTTOM_CNT  = cnt_t'((ROWS - 1) * COLS);

	// Item kinds on the input channel
	typedef enum logic [KIND_W-1:0] {
		KIND_PRINT  = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_SETCUR = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// Operations after classification
	typedef enum logic [2:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_ERASE,
		OP_SETCUR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  hit;   // position lies on the screen
		byte_t ch;
		byte_t attr;
		addr_t addr;
		ridx_t row;
		cidx_t col;
	} cmd_t;

endpackage

FILE: src/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/tcw_front.sv
// Front end: accepts items, splits positions into row and column, builds commands.
// Depends on tcw_pkg.
module tcw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hold,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tcw_pkg::KIND_W-1:0] kind,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::CHAR_W-1:0] color,
	input  logic [tcw_pkg::CHAR_W-1:0] blink_char,
	input  logic [tcw_pkg::POS_W-1:0]  position,
	input  logic [tcw_pkg::COL_W-1:0]  column,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  tcw_pkg::byte_t             prompt_char,
	input  tcw_pkg::byte_t             prompt_color,
	input  tcw_pkg::byte_t             erase_attr,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output tcw_pkg::cmd_t             cmd
);

	logic                       valid_s1;
	logic [tcw_pkg::KIND_W-1:0] kind_s1;
	tcw_pkg::byte_t             char_s1;
	tcw_pkg::byte_t             color_s1;
	tcw_pkg::byte_t             blink_s1;
	tcw_pkg::pos_t              pos_s1;
	logic [tcw_pkg::COL_W-1:0]  col_s1;
	logic [tcw_pkg::ROW_W-1:0]  row_s1;
	tcw_pkg::quo_t              quo_s1;

	tcw_pkg::prod_t prod;
	tcw_pkg::pos_t  rem_raw;
	logic           rem_big;
	tcw_pkg::quo_t  quo_fix;
	tcw_pkg::pos_t  rem_fix;
	tcw_pkg::cidx_t col_sat;
	tcw_pkg::ridx_t row_sat;
	logic           accept;

	assign in_ready  = !hold && (!valid_s1 || cmd_ready);
	assign accept    = in_valid && in_ready;
	assign cmd_valid = valid_s1;

	// Estimate of position / COLS, at most one below the true quotient
	assign prod = tcw_pkg::prod_t'(position) * tcw_pkg::prod_t'(tcw_pkg::DIV_RECIP);

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			char_s1  <= char_code;
			color_s1 <= color;
			blink_s1 <= blink_char;
			pos_s1   <= position;
			col_s1   <= column;
			row_s1   <= row;
			quo_s1   <= tcw_pkg::quo_t'(prod >> tcw_pkg::DIV_SHIFT);
		end
	end

	// Correct the quotient estimate with one compare and subtract
	always_comb begin
		rem_raw = tcw_pkg::pos_t'(pos_s1 - tcw_pkg::pos_t'(quo_s1 * tcw_pkg::COLS));
		rem_big = (rem_raw >= tcw_pkg::COLS);
		quo_fix = rem_big ? tcw_pkg::quo_t'(quo_s1 + 1'b1) : quo_s1;
		rem_fix = rem_big ? tcw_pkg::pos_t'(rem_raw - tcw_pkg::COLS) : rem_raw;
	end

	// Saturate the set-cursor target
	always_comb begin
		col_sat = (col_s1 > tcw_pkg::COLS - 1) ? tcw_pkg::LAST_COL : tcw_pkg::cidx_t'(col_s1);
		row_sat = (row_s1 > tcw_pkg::ROWS - 1) ? tcw_pkg::LAST_ROW : tcw_pkg::ridx_t'(row_s1);
	end

	// Classify the item into a command
	always_comb begin
		cmd      = '0;
		cmd.op   = tcw_pkg::OP_PRINT;
		cmd.hit  = (pos_s1 < tcw_pkg::CELLS);
		cmd.addr = tcw_pkg::addr_t'(pos_s1);
		cmd.row  = tcw_pkg::ridx_t'(quo_fix);
		cmd.col  = tcw_pkg::cidx_t'(rem_fix);
		unique case (tcw_pkg::kind_t'(kind_s1))
			tcw_pkg::KIND_PRINT: begin
				if (char_s1 == tcw_pkg::NEWLINE_CODE) begin
					cmd.op   = tcw_pkg::OP_NEWLINE;
					cmd.ch   = prompt_char;
					cmd.attr = prompt_color |
						((prompt_char == tcw_pkg::BLANK_CHAR) ? tcw_pkg::BLINK_BIT : '0);
				end else begin
					cmd.op   = tcw_pkg::OP_PRINT;
					cmd.ch   = char_s1;
					cmd.attr = color_s1 | ((char_s1 == blink_s1) ? tcw_pkg::BLINK_BIT : '0);
				end
			end
			tcw_pkg::KIND_ERASE: begin
				cmd.op   = tcw_pkg::OP_ERASE;
				cmd.ch   = tcw_pkg::BLANK_CHAR;
				cmd.attr = erase_attr;
			end
			tcw_pkg::KIND_SETCUR: begin
				cmd.op   = tcw_pkg::OP_SETCUR;
				cmd.row  = row_sat;
				cmd.col  = col_sat;
				cmd.addr = tcw_pkg::addr_t'(tcw_pkg::addr_t'(row_sat) *
					tcw_pkg::addr_t'(tcw_pkg::COLS)) + tcw_pkg::addr_t'(col_sat);
			end
			tcw_pkg::KIND_READ: begin
				cmd.op = tcw_pkg::OP_READ;
			end
		endcase
	end

endmodule

FILE: src/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcw_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcw_pkg::cmd_t pop_cmd
);

	tcw_pkg::cmd_t  slot_q [tcw_pkg::QDEPTH];
	tcw_pkg::qptr_t wr_ptr_q;
	tcw_pkg::qptr_t rd_ptr_q;
	tcw_pkg::qcnt_t count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != tcw_pkg::qcnt_t'(tcw_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tcw_pkg::qptr_t'(tcw_pkg::QDEPTH - 1)) ? '0 :
					tcw_pkg::qptr_t'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tcw_pkg::qptr_t'(tcw_pkg::QDEPTH - 1)) ? '0 :
					tcw_pkg::qptr_t'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= tcw_pkg::qcnt_t'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= tcw_pkg::qcnt_t'(count_q - 1'b1);
			end
		end
	end

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: src/tcw_back.sv
// Back end: owns the cell store and cursor, runs commands, scrolls and clears.
// Depends on tcw_pkg and tcw_ram.
module tcw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tcw_pkg::byte_t             erase_attr,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  tcw_pkg::cmd_t              cmd,
	output logic                       clearing,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tcw_pkg::POS_W-1:0]  cursor_at,
	output logic [tcw_pkg::CHAR_W-1:0] cell_char,
	output logic [tcw_pkg::CHAR_W-1:0] cell_attr
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_BLANK,
		ST_PROMPT,
		ST_DONE
	} state_t;

	state_t         state_q;
	tcw_pkg::cmd_t  cmd_q;
	tcw_pkg::ridx_t row_q;
	tcw_pkg::cidx_t col_q;
	tcw_pkg::addr_t lin_q;
	tcw_pkg::cnt_t  idx_q;
	logic           swr_valid_s1;
	tcw_pkg::addr_t swr_addr_s1;
	logic           out_valid_q;
	tcw_pkg::pos_t  cursor_at_q;
	tcw_pkg::byte_t cell_char_q;
	tcw_pkg::byte_t cell_attr_q;

	logic           ram_we;
	tcw_pkg::addr_t ram_waddr;
	tcw_pkg::cell_t ram_wdata;
	logic           ram_re;
	tcw_pkg::addr_t ram_raddr;
	tcw_pkg::cell_t ram_rdata;
	logic           scroll_rd;
	logic           out_free;
	logic           at_last;

	assign cmd_ready = (state_q == ST_IDLE);
	assign clearing  = (state_q == ST_CLEAR);
	assign out_valid = out_valid_q;
	assign cursor_at = cursor_at_q;
	assign cell_char = cell_char_q;
	assign cell_attr = cell_attr_q;
	assign out_free  = !out_valid_q || out_ready;
	assign at_last   = (row_q == tcw_pkg::LAST_ROW) && (col_q == tcw_pkg::LAST_COL);
	assign scroll_rd = (state_q == ST_SCROLL) && (idx_q != tcw_pkg::CELL_COUNT);

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Read port: scroll source or a cell read
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[tcw_pkg::ADDR_W-1:0];
		if (scroll_rd) begin
			ram_re = 1'b1;
		end else if (state_q == ST_EXEC && cmd_q.op == tcw_pkg::OP_READ) begin
			ram_re    = cmd_q.hit;
			ram_raddr = cmd_q.addr;
		end
	end

	// Write port: pending scroll copy first, then the state's own write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lin_q;
		ram_wdata = '0;
		if (swr_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = swr_addr_s1;
			ram_wdata = ram_rdata;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[tcw_pkg::ADDR_W-1:0];
				end
				ST_EXEC: begin
					if (cmd_q.op == tcw_pkg::OP_PRINT) begin
						ram_we    = 1'b1;
						ram_wdata = {cmd_q.attr, cmd_q.ch};
					end else if (cmd_q.op == tcw_pkg::OP_ERASE) begin
						ram_we    = cmd_q.hit;
						ram_waddr = cmd_q.addr;
						ram_wdata = {cmd_q.attr, tcw_pkg::BLANK_CHAR};
					end
				end
				ST_BLANK: begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[tcw_pkg::ADDR_W-1:0];
					ram_wdata = {erase_attr, tcw_pkg::BLANK_CHAR};
				end
				ST_PROMPT: begin
					ram_we    = 1'b1;
					ram_wdata = {cmd_q.attr, cmd_q.ch};
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	// Sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cmd_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			lin_q        <= '0;
			idx_q        <= '0;
			swr_valid_s1 <= 1'b0;
			swr_addr_s1  <= '0;
			out_valid_q  <= 1'b0;
			cursor_at_q  <= '0;
			cell_char_q  <= '0;
			cell_attr_q  <= '0;
		end else begin
			// Scroll copy lands one row up, in the cycle after its read
			swr_valid_s1 <= scroll_rd;
			swr_addr_s1  <= tcw_pkg::addr_t'(idx_q - tcw_pkg::COLS);

			// Drop the result once taken
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= tcw_pkg::cnt_t'(idx_q + 1'b1);
					if (idx_q == tcw_pkg::LAST_CELL) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (cmd_q.op)
						tcw_pkg::OP_PRINT: begin
							if (at_last) begin
								col_q   <= '0;
								lin_q   <= tcw_pkg::BOTTOM_BASE;
								idx_q   <= tcw_pkg::SCROLL_SRC;
								state_q <= ST_SCROLL;
							end else if (col_q == tcw_pkg::LAST_COL) begin
								col_q <= '0;
								row_q <= tcw_pkg::ridx_t'(row_q + 1'b1);
								lin_q <= tcw_pkg::addr_t'(lin_q + 1'b1);
							end else begin
								col_q <= tcw_pkg::cidx_t'(col_q + 1'b1);
								lin_q <= tcw_pkg::addr_t'(lin_q + 1'b1);
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							col_q <= '0;
							if (row_q == tcw_pkg::LAST_ROW) begin
								lin_q   <= tcw_pkg::BOTTOM_BASE;
								idx_q   <= tcw_pkg::SCROLL_SRC;
								state_q <= ST_SCROLL;
							end else begin
								row_q   <= tcw_pkg::ridx_t'(row_q + 1'b1);
								lin_q   <= tcw_pkg::addr_t'(lin_q - tcw_pkg::addr_t'(col_q) +
									tcw_pkg::addr_t'(tcw_pkg::COLS));
								state_q <= ST_PROMPT;
							end
						end
						tcw_pkg::OP_ERASE: begin
							if (cmd_q.hit) begin
								row_q <= cmd_q.row;
								col_q <= cmd_q.col;
								lin_q <= cmd_q.addr;
							end
						end
						tcw_pkg::OP_SETCUR: begin
							row_q <= cmd_q.row;
							col_q <= cmd_q.col;
							lin_q <= cmd_q.addr;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SCROLL: begin
					if (idx_q == tcw_pkg::CELL_COUNT) begin
						idx_q   <= tcw_pkg::BOTTOM_CNT;
						state_q <= ST_BLANK;
					end else begin
						idx_q <= tcw_pkg::cnt_t'(idx_q + 1'b1);
					end
				end
				ST_BLANK: begin
					idx_q <= tcw_pkg::cnt_t'(idx_q + 1'b1);
					if (idx_q == tcw_pkg::LAST_CELL) begin
						state_q <= (cmd_q.op == tcw_pkg::OP_NEWLINE) ? ST_PROMPT : ST_DONE;
					end
				end
				ST_PROMPT: begin
					col_q   <= tcw_pkg::cidx_t'(1);
					lin_q   <= tcw_pkg::addr_t'(lin_q + 1'b1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cursor_at_q <= tcw_pkg::pos_t'(lin_q);
						if (cmd_q.op == tcw_pkg::OP_READ && cmd_q.hit) begin
							cell_char_q <= ram_rdata[tcw_pkg::CHAR_W-1:0];
							cell_attr_q <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
						end else begin
							cell_char_q <= '0;
							cell_attr_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/text_console_writer_top.sv
// Top level of the text console writer: configuration registers, front, queue, back.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: print char (newline on
//   code 0x0a), erase at position, set cursor or read cell. Output channel
//   (out_valid/out_ready) returns one result per item, in order: the cursor
//   position after the item and, for a read, the cell's character and attribute.
//   Configuration (cfg_wen, cfg_index, cfg_data) is to be written by the user only
//   while the block is idle; the block does not enforce it. Indexes 0..2 are prompt
//   character, prompt colour and erase attribute. After reset the cell store is
//   cleared, one cell a cycle; in_ready stays low during that pass and the cursor
//   sits at 0. The back end runs one item at a time through its execute and done
//   states, with a prompt state after a newline. A print past the last cell or a
//   newline on the bottom row scrolls: copying through the one read and one write
//   port of the cell RAM, then blanking the bottom row. A front stage and a
//   two-entry command queue keep taking items while a result waits; when the
//   receiver stalls, the held result stays put and the input stalls only once the
//   queue and front stage are full.
`include "text_console_writer_top_macros.svh"

module text_console_writer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::CHAR_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcw_pkg::KIND_W-1:0]    kind,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::CHAR_W-1:0]    color,
	input  logic [tcw_pkg::CHAR_W-1:0]    blink_char,
	input  logic [tcw_pkg::POS_W-1:0]     position,
	input  logic [tcw_pkg::COL_W-1:0]     column,
	input  logic [tcw_pkg::ROW_W-1:0]     row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::POS_W-1:0]     cursor_at,
	output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
	output logic [tcw_pkg::CHAR_W-1:0]    cell_attr
);

	tcw_pkg::byte_t prompt_char_q;
	tcw_pkg::byte_t prompt_color_q;
	tcw_pkg::byte_t erase_attr_q;

	logic          st_clearing;
	logic          fq_valid;
	logic          fq_ready;
	tcw_pkg::cmd_t fq_cmd;
	logic          qb_valid;
	logic          qb_ready;
	tcw_pkg::cmd_t qb_cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prompt_char_q  <= tcw_pkg::PROMPT_CHAR_RST;
			prompt_color_q <= tcw_pkg::PROMPT_COLOR_RST;
			erase_attr_q   <= tcw_pkg::ERASE_ATTR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tcw_pkg::CFG_PROMPT_CHAR:  prompt_char_q  <= cfg_data;
				tcw_pkg::CFG_PROMPT_COLOR: prompt_color_q <= cfg_data;
				tcw_pkg::CFG_ERASE_ATTR:   erase_attr_q   <= cfg_data;
				default: begin
					prompt_char_q <= prompt_char_q;
				end
			endcase
		end
	end

	tcw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (st_clearing),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.char_code   (char_code),
		.color       (color),
		.blink_char  (blink_char),
		.position    (position),
		.column      (column),
		.row         (row),
		.prompt_char (prompt_char_q),
		.prompt_color(prompt_color_q),
		.erase_attr  (erase_attr_q),
		.cmd_valid   (fq_valid),
		.cmd_ready   (fq_ready),
		.cmd         (fq_cmd)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_cmd  (fq_cmd),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_cmd   (qb_cmd)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.erase_attr(erase_attr_q),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.clearing  (st_clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cursor_at (cursor_at),
		.cell_char (cell_char),
		.cell_attr (cell_attr)
	);

	// Checks
	`TCW_ASSERT_IMPL(a_clear_blocks_input, st_clearing, !in_ready)
	`TCW_ASSERT_NEXT(a_clear_runs_once, !st_clearing, !st_clearing)
	`TCW_ASSERT_IMPL(a_no_result_while_clearing, st_clearing, !out_valid)
	`TCW_ASSERT_IMPL(a_cursor_on_screen, out_valid, cursor_at < tcw_pkg::CELLS)

endmodule

FILE: test/tb_text_console_writer_top.sv
// Self-checking testbench for text_console_writer_top: directed cases, then random phases.
// Depends on tcw_pkg and the text console writer RTL; the console is modelled in-line.
module tb_text_console_writer_top;
	import tcw_pkg::*;

	localparam int RANDOM_ITEMS = 640;
	localparam int PHASES       = 4;
	localparam int SCROLL_CAP   = 40;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 8;

	typedef struct {
		kind_t      kind;
		byte_t      ch;
		byte_t      color;
		byte_t      blink;
		pos_t       pos;
		logic [6:0] col;
		logic [4:0] rw;
	} console_item_t;

	typedef struct {
		pos_t  cursor;
		byte_t ch;
		byte_t attr;
	} console_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CHAR_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_code;
	logic [CHAR_W-1:0] color;
	logic [CHAR_W-1:0] blink_char;
	logic [POS_W-1:0] position;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [POS_W-1:0] cursor_at;
	logic [CHAR_W-1:0] cell_char;
	logic [CHAR_W-1:0] cell_attr;

	// Console model state
	cell_t screen [CELLS];
	int unsigned model_cursor;
	byte_t prompt_char_r;
	byte_t prompt_color_r;
	byte_t erase_attr_r;
	int scroll_count;

	console_result_t pending_results [$];
	int errors = 0;
	logic idle_on = 1'b1;
	int stall_left = 0;

	text_console_writer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .char_code(char_code), .color(color), .blink_char(blink_char),
		.position(position), .column(column), .row(row),
		.out_valid(out_valid), .out_ready(out_ready),
		.cursor_at(cursor_at), .cell_char(cell_char), .cell_attr(cell_attr)
	);

	always #10 clk = ~clk;

	// Watchdog
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	// Console model
	function automatic void reset_console_model();
		foreach (screen[i]) screen[i] = '0;
		model_cursor = 0;
		prompt_char_r = PROMPT_CHAR_RST;
		prompt_color_r = PROMPT_COLOR_RST;
		erase_attr_r = ERASE_ATTR_RST;
		scroll_count = 0;
	endfunction

	// Keep row 0, drop row 1, shift the rest up and blank the bottom row
	function automatic void scroll_screen();
		for (int i = COLS; i < (ROWS - 1) * COLS; i++)
			screen[i] = screen[i + COLS];
		for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
			screen[i] = {erase_attr_r, BLANK_CHAR};
		scroll_count++;
	endfunction

	function automatic void step_cursor();
		int unsigned y;
		int unsigned x;
		y = model_cursor / COLS;
		x = model_cursor % COLS + 1;
		if (x == COLS) begin
			x = 0;
			y++;
		end
		if (y >= ROWS) begin
			scroll_screen();
			x = 0;
			y = ROWS - 1;
		end
		model_cursor = y * COLS + x;
	endfunction

	function automatic void put_glyph(byte_t ch, byte_t attr, byte_t blink);
		byte_t a;
		a = attr;
		if (ch == blink)
			a = a | BLINK_BIT;
		if (model_cursor < CELLS)
			screen[model_cursor] = {a, ch};
		step_cursor();
	endfunction

	// The prompt always goes in as a plain glyph with blink character zero
	function automatic void start_line();
		int unsigned y;
		y = model_cursor / COLS + 1;
		if (y >= ROWS) begin
			scroll_screen();
			y = ROWS - 1;
		end
		model_cursor = y * COLS;
		put_glyph(prompt_char_r, prompt_color_r, 8'h00);
	endfunction

	function automatic console_result_t apply_console_item(console_item_t it);
		console_result_t res;
		int unsigned c;
		int unsigned r;
		res.ch = '0;
		res.attr = '0;
		case (it.kind)
			KIND_PRINT: begin
				if (it.ch == NEWLINE_CODE)
					start_line();
				else
					put_glyph(it.ch, it.color, it.blink);
			end
			KIND_ERASE: begin
				if (it.pos < CELLS) begin
					screen[it.pos] = {erase_attr_r, BLANK_CHAR};
					model_cursor = 32'(it.pos);
				end
			end
			KIND_SETCUR: begin
				c = (it.col > COLS - 1) ? COLS - 1 : 32'(it.col);
				r = (it.rw > ROWS - 1) ? ROWS - 1 : 32'(it.rw);
				model_cursor = r * COLS + c;
			end
			default: begin
				if (it.pos < CELLS) begin
					res.ch = screen[it.pos][7:0];
					res.attr = screen[it.pos][15:8];
				end
			end
		endcase
		res.cursor = pos_t'(model_cursor);
		return res;
	endfunction

	function automatic bit causes_scroll(console_item_t it);
		if (it.kind != KIND_PRINT)
			return 1'b0;
		if (it.ch == NEWLINE_CODE)
			return model_cursor / COLS == ROWS - 1;
		return model_cursor == CELLS - 1;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (errors < 100)
			$display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Receiver stalls in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_ready <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18);
			out_ready <= 1'b0;
		end
	end

	// Compare each result item with the oldest prediction
	always @(negedge clk) begin : result_check
		console_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no item outstanding", 32'(cursor_at), 0);
			end else begin
				want = pending_results.pop_front();
				if (cursor_at !== want.cursor)
					report_mismatch("cursor_at", 32'(cursor_at), 32'(want.cursor));
				if (cell_char !== want.ch)
					report_mismatch("cell_char", 32'(cell_char), 32'(want.ch));
				if (cell_attr !== want.attr)
					report_mismatch("cell_attr", 32'(cell_attr), 32'(want.attr));
			end
		end
	end

	// Drive one item, hold it until accepted, then predict its result
	task automatic send_item(console_item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		char_code <= it.ch;
		color <= it.color;
		blink_char <= it.blink;
		position <= it.pos;
		column <= it.col;
		row <= it.rw;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_results.push_back(apply_console_item(it));
	endtask

	function automatic console_item_t noise_item();
		console_item_t it;
		it.kind = kind_t'($urandom_range(0, 3));
		it.ch = byte_t'($urandom);
		it.color = byte_t'($urandom);
		it.blink = byte_t'($urandom);
		it.pos = pos_t'($urandom_range(0, 2047));
		it.col = 7'($urandom_range(0, 127));
		it.rw = 5'($urandom_range(0, 31));
		return it;
	endfunction

	task automatic print_char(byte_t ch, byte_t attr, byte_t blink);
		console_item_t it;
		it = noise_item();
		it.kind = KIND_PRINT;
		it.ch = ch;
		it.color = attr;
		it.blink = blink;
		send_item(it);
	endtask

	task automatic erase_at(pos_t pos);
		console_item_t it;
		it = noise_item();
		it.kind = KIND_ERASE;
		it.pos = pos;
		send_item(it);
	endtask

	task automatic place_cursor(logic [6:0] col, logic [4:0] rw);
		console_item_t it;
		it = noise_item();
		it.kind = KIND_SETCUR;
		it.col = col;
		it.rw = rw;
		send_item(it);
	endtask

	task automatic read_cell(pos_t pos);
		console_item_t it;
		it = noise_item();
		it.kind = KIND_READ;
		it.pos = pos;
		send_item(it);
	endtask

	// Wait until every result is back and the block has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; only while idle
	task automatic set_regs(byte_t p_char, byte_t p_color, byte_t e_attr);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_PROMPT_CHAR;
		cfg_data <= p_char;
		@(posedge clk);
		cfg_index <= CFG_PROMPT_COLOR;
		cfg_data <= p_color;
		@(posedge clk);
		cfg_index <= CFG_ERASE_ATTR;
		cfg_data <= e_attr;
		@(posedge clk);
		cfg_wen <= 1'b0;
		prompt_char_r = p_char;
		prompt_color_r = p_color;
		erase_attr_r = e_attr;
	endtask

	// The store must read back as zero after the clearing pass
	task automatic test_cleared_store();
		read_cell(pos_t'(0));
		read_cell(pos_t'(CELLS - 1));
	endtask

	// Extreme glyph and colour values, blink match on zero and on a letter
	task automatic test_print_extremes();
		print_char(8'h00, 8'h00, 8'h00);
		print_char(8'hff, 8'hff, 8'h00);
		print_char(8'h41, 8'h07, 8'h41);
		read_cell(pos_t'(0));
		read_cell(pos_t'(2));
	endtask

	task automatic test_newline_prompt();
		print_char(NEWLINE_CODE, byte_t'($urandom), byte_t'($urandom));
		read_cell(pos_t'(COLS));
	endtask

	// Saturating set cursor, then wrap at the end of a row
	task automatic test_cursor_setting();
		place_cursor(7'd127, 5'd31);
		place_cursor(7'(COLS - 1), 5'd0);
		print_char(8'h5a, 8'h1e, 8'h00);
	endtask

	// Scroll from a print at the last cell and from a newline on the bottom row
	task automatic test_scrolling();
		place_cursor(7'(COLS - 1), 5'(ROWS - 1));
		print_char(8'h41, 8'h4f, 8'h00);
		read_cell(pos_t'((ROWS - 1) * COLS - 1));
		read_cell(pos_t'((ROWS - 1) * COLS));
		print_char(NEWLINE_CODE, byte_t'($urandom), byte_t'($urandom));
		read_cell(pos_t'((ROWS - 1) * COLS + 1));
	endtask

	// Erase and read off the end of the screen, and erase in range
	task automatic test_erase_range();
		erase_at(pos_t'(2047));
		erase_at(pos_t'(0));
		read_cell(pos_t'(CELLS));
		read_cell(pos_t'(0));
	endtask

	// Prompt equal to newline, and a zero prompt that picks up the blink bit
	task automatic test_prompt_cases();
		drain_results();
		set_regs(NEWLINE_CODE, 8'hff, 8'hff);
		print_char(NEWLINE_CODE, byte_t'($urandom), byte_t'($urandom));
		read_cell(pos_t'(model_cursor - 1));
		drain_results();
		set_regs(8'h00, 8'h00, 8'h00);
		print_char(NEWLINE_CODE, byte_t'($urandom), byte_t'($urandom));
		read_cell(pos_t'(model_cursor - 1));
	endtask

	function automatic console_item_t random_console_item();
		console_item_t it;
		int unsigned pick;
		it = noise_item();
		pick = $urandom_range(0, 99);
		if (pick < 52) begin
			it.kind = KIND_PRINT;
			if ($urandom_range(0, 2) == 0)
				it.blink = it.ch;
		end else if (pick < 60) begin
			it.kind = KIND_PRINT;
			it.ch = NEWLINE_CODE;
		end else if (pick < 74) begin
			it.kind = KIND_SETCUR;
			if ($urandom_range(0, 7) != 0) begin
				it.col = 7'($urandom_range(0, COLS - 1));
				it.rw = 5'($urandom_range(0, ROWS - 1));
			end
			// Aim near the end of the screen now and then
			if ($urandom_range(0, 5) == 0) begin
				it.rw = 5'(ROWS - 1);
				it.col = 7'($urandom_range(COLS - 10, COLS - 1));
			end
		end else if (pick < 85) begin
			it.kind = KIND_ERASE;
			it.pos = pos_t'(($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, 2047)
			                                            : $urandom_range(0, CELLS - 1));
		end else begin
			it.kind = KIND_READ;
			if ($urandom_range(0, 1) == 0)
				it.pos = pos_t'((model_cursor == 0) ? 0 : model_cursor - 1);
			else
				it.pos = pos_t'(($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, 2047)
				                                            : $urandom_range(0, CELLS - 1));
		end
		// Hold scrolls to a bounded number, as each one copies most of the cell store
		if (causes_scroll(it) && scroll_count >= SCROLL_CAP) begin
			it.kind = KIND_SETCUR;
			it.col = 7'($urandom_range(0, COLS - 1));
			it.rw = 5'($urandom_range(0, ROWS - 2));
		end
		return it;
	endfunction

	// Random items in phases with fresh register settings; the last phase runs flat out
	task automatic test_random_traffic();
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: set_regs(8'h00, 8'hff, 8'h00);
				1: set_regs(8'hff, 8'h00, 8'hff);
				default: set_regs(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
			endcase
			idle_on = (ph != PHASES - 1);
			repeat (RANDOM_ITEMS / PHASES) send_item(random_console_item());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = '0;
		char_code = '0;
		color = '0;
		blink_char = '0;
		position = '0;
		column = '0;
		row = '0;
		reset_console_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_cleared_store();
		test_print_extremes();
		test_newline_prompt();
		test_cursor_setting();
		test_scrolling();
		test_erase_range();
		test_prompt_cases();
		test_random_traffic();

		drain_results();
		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), 0);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
